### design/fbc_pkg.sv
// Shared types and constants for the frustum box cull unit.
`timescale 1ns / 1ps
`default_nettype none
package fbc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int COORD_W    = 20;
  localparam int EXTENT_W   = 16;
  localparam int HI_W       = COORD_W + 1;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = COEF_W + HI_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int PLANE_W    = 4 * COEF_W;
  localparam int CORNER_W   = NUM_AXES * COORD_W;
  localparam int REG_IDX_W  = 3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Register indexes on the configuration port.
  localparam reg_idx_t REG_PLANE_NEAR   = 3'd0;
  localparam reg_idx_t REG_PLANE_RIGHT  = 3'd1;
  localparam reg_idx_t REG_PLANE_LEFT   = 3'd2;
  localparam reg_idx_t REG_PLANE_TOP    = 3'd3;
  localparam reg_idx_t REG_PLANE_BOTTOM = 3'd4;
  localparam reg_idx_t REG_PLANE_FAR    = 3'd5;
  localparam reg_idx_t REG_CORNER_LOW   = 3'd6;
  localparam reg_idx_t REG_CORNER_HIGH  = 3'd7;

  // Query command codes.
  localparam logic CMD_BOX   = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // One query as it travels down the row of cells.
  typedef struct packed {
    logic                              valid;
    logic                              is_point;
    logic                              visible;
    logic [NUM_AXES-1:0][COORD_W-1:0]  lo;
    logic [NUM_AXES-1:0][HI_W-1:0]     hi;
  } query_t;

endpackage
`default_nettype wire

### design/fbc_plane_cell.sv
// One plane cell: holds one frustum plane and tests each passing query against it.
`timescale 1ns / 1ps
`default_nettype none
module fbc_plane_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [fbc_pkg::PLANE_W-1:0] cfg_data,
  input  wire fbc_pkg::query_t             q_in,
  output fbc_pkg::query_t                  q_out
);

  logic [fbc_pkg::PLANE_W-1:0] plane_r;
  fbc_pkg::query_t             q1_r;
  fbc_pkg::query_t             q2_r;
  fbc_pkg::query_t             q2_nxt;
  logic signed [fbc_pkg::PROD_W-1:0] prod_nxt [fbc_pkg::NUM_AXES];
  logic signed [fbc_pkg::PROD_W-1:0] prod_r   [fbc_pkg::NUM_AXES];
  logic [fbc_pkg::COEF_W-1:0]        d_r;
  logic signed [fbc_pkg::DOT_W-1:0]  dot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_we) begin
      plane_r <= cfg_data;
    end
  end

  // Stage one: pick the corner farthest in front of the plane and multiply.
  // A point uses its origin on every axis.
  always_comb begin
    logic signed [fbc_pkg::COEF_W-1:0] coef;
    logic signed [fbc_pkg::HI_W-1:0]   sel;
    for (int k = 0; k < fbc_pkg::NUM_AXES; k++) begin
      coef = $signed(plane_r[k*fbc_pkg::COEF_W +: fbc_pkg::COEF_W]);
      if (q_in.is_point == fbc_pkg::CMD_BOX && !coef[fbc_pkg::COEF_W-1]) begin
        sel = $signed(q_in.hi[k]);
      end else begin
        sel = $signed({q_in.lo[k][fbc_pkg::COORD_W-1], q_in.lo[k]});
      end
      prod_nxt[k] = fbc_pkg::PROD_W'(coef) * fbc_pkg::PROD_W'(sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r <= '0;
    end else begin
      q1_r <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fbc_pkg::NUM_AXES; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    d_r <= plane_r[3*fbc_pkg::COEF_W +: fbc_pkg::COEF_W];
  end

  // Stage two: sum the products and the offset term, which is d scaled by 16
  // so that all terms carry 18 fraction bits.
  assign dot = {{2{prod_r[0][fbc_pkg::PROD_W-1]}}, prod_r[0]}
             + {{2{prod_r[1][fbc_pkg::PROD_W-1]}}, prod_r[1]}
             + {{2{prod_r[2][fbc_pkg::PROD_W-1]}}, prod_r[2]}
             + {{(fbc_pkg::DOT_W-fbc_pkg::COEF_W-4){d_r[fbc_pkg::COEF_W-1]}}, d_r, 4'b0000};

  always_comb begin
    q2_nxt         = q1_r;
    q2_nxt.visible = q1_r.visible & ~dot[fbc_pkg::DOT_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_r <= '0;
    end else begin
      q2_r <= q2_nxt;
    end
  end

  assign q_out = q2_r;

endmodule
`default_nettype wire

### design/fbc_bounds_check.sv
// Last cell: holds the frustum corner bounds and registers the final result.
`timescale 1ns / 1ps
`default_nettype none
module fbc_bounds_check (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         low_we,
  input  wire logic                         high_we,
  input  wire logic [fbc_pkg::CORNER_W-1:0] cfg_data,
  input  wire fbc_pkg::query_t              q_in,
  output logic                              out_valid,
  output logic                              out_visible
);

  logic [fbc_pkg::CORNER_W-1:0] corner_low_r;
  logic [fbc_pkg::CORNER_W-1:0] corner_high_r;
  logic                         out_valid_r;
  logic                         out_visible_r;
  logic                         outside;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_low_r  <= '0;
      corner_high_r <= '0;
    end else begin
      if (low_we) begin
        corner_low_r <= cfg_data;
      end
      if (high_we) begin
        corner_high_r <= cfg_data;
      end
    end
  end

  // The box is rejected when every frustum corner lies past one of its faces.
  always_comb begin
    logic signed [fbc_pkg::HI_W-1:0] clo;
    logic signed [fbc_pkg::HI_W-1:0] chi;
    logic signed [fbc_pkg::HI_W-1:0] blo;
    outside = 1'b0;
    for (int k = 0; k < fbc_pkg::NUM_AXES; k++) begin
      clo = $signed({corner_low_r[k*fbc_pkg::COORD_W + fbc_pkg::COORD_W-1],
                     corner_low_r[k*fbc_pkg::COORD_W +: fbc_pkg::COORD_W]});
      chi = $signed({corner_high_r[k*fbc_pkg::COORD_W + fbc_pkg::COORD_W-1],
                     corner_high_r[k*fbc_pkg::COORD_W +: fbc_pkg::COORD_W]});
      blo = $signed({q_in.lo[k][fbc_pkg::COORD_W-1], q_in.lo[k]});
      if (clo > $signed(q_in.hi[k]) || chi < blo) begin
        outside = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= q_in.visible & ~(q_in.is_point == fbc_pkg::CMD_BOX && outside);
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule
`default_nettype wire

### design/frustum_box_cull_unit.sv
// Top level of the frustum box cull unit: entry stage, row of plane cells, bounds cell.
//
// Usage: a query (point or box) is offered on the in_ ports with start high;
// it is accepted at a rising edge where start is high and busy is low. busy
// stays low, so a new query may be issued in every cycle.
// Each query produces one result: out_valid is high for one cycle with
// out_visible, once the query has passed fourteen registers (one entry stage
// that forms the box maximum, two stages in each of the six plane cells, and
// the bounds cell). Throughput is one query per cycle; results leave in order.
// The six plane cells form a chain; each holds one plane and hands the query
// and its running visibility flag to its neighbor every cycle.
// Configuration transactions on the cfg_ port are always ready; register
// index 0..5 writes the planes, 6 and 7 the frustum corner bounds. Write
// configuration only while no query is in flight.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
// Reset (rst_n low, synchronous) empties the pipeline and clears all
// configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module frustum_box_cull_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic signed [fbc_pkg::COORD_W-1:0]  in_origin_x,
  input  wire logic signed [fbc_pkg::COORD_W-1:0]  in_origin_y,
  input  wire logic signed [fbc_pkg::COORD_W-1:0]  in_origin_z,
  input  wire logic [fbc_pkg::EXTENT_W-1:0]  in_extent_x,
  input  wire logic [fbc_pkg::EXTENT_W-1:0]  in_extent_y,
  input  wire logic [fbc_pkg::EXTENT_W-1:0]  in_extent_z,
  output logic                               out_valid,
  output logic                               out_visible,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire fbc_pkg::reg_idx_t             cfg_index,
  input  wire logic [fbc_pkg::PLANE_W-1:0]   cfg_data
);

  fbc_pkg::query_t entry_nxt;
  fbc_pkg::query_t entry_r;
  fbc_pkg::query_t chain [fbc_pkg::NUM_PLANES+1];
  logic            cfg_wr;
  logic [fbc_pkg::COORD_W-1:0]  org  [fbc_pkg::NUM_AXES];
  logic [fbc_pkg::EXTENT_W-1:0] ext  [fbc_pkg::NUM_AXES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign ext[0] = in_extent_x;
  assign ext[1] = in_extent_y;
  assign ext[2] = in_extent_z;

  // Entry stage: the box maximum is one bit wider than the origin.
  always_comb begin
    entry_nxt          = '0;
    entry_nxt.valid    = start & ~busy;
    entry_nxt.is_point = in_command;
    entry_nxt.visible  = 1'b1;
    for (int k = 0; k < fbc_pkg::NUM_AXES; k++) begin
      entry_nxt.lo[k] = org[k];
      entry_nxt.hi[k] = {org[k][fbc_pkg::COORD_W-1], org[k]}
                      + {{(fbc_pkg::HI_W-fbc_pkg::EXTENT_W){1'b0}}, ext[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign chain[0] = entry_r;

  for (genvar i = 0; i < fbc_pkg::NUM_PLANES; i++) begin : g_cell
    fbc_plane_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg_we   (cfg_wr && cfg_index == fbc_pkg::reg_idx_t'(fbc_pkg::REG_PLANE_NEAR + i)),
      .cfg_data (cfg_data),
      .q_in     (chain[i]),
      .q_out    (chain[i+1])
    );
  end

  fbc_bounds_check u_bounds (
    .clk         (clk),
    .rst_n       (rst_n),
    .low_we      (cfg_wr && cfg_index == fbc_pkg::REG_CORNER_LOW),
    .high_we     (cfg_wr && cfg_index == fbc_pkg::REG_CORNER_HIGH),
    .cfg_data    (cfg_data[fbc_pkg::CORNER_W-1:0]),
    .q_in        (chain[fbc_pkg::NUM_PLANES]),
    .out_valid   (out_valid),
    .out_visible (out_visible)
  );

endmodule
`default_nettype wire

### verif/cull_checker.sv
// Checker for the frustum box cull unit: mirrors its configuration and predicts every result.
`timescale 1ns / 1ps
module cull_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic                                   in_command,
  input  logic signed [fbc_pkg::COORD_W-1:0]     in_origin_x,
  input  logic signed [fbc_pkg::COORD_W-1:0]     in_origin_y,
  input  logic signed [fbc_pkg::COORD_W-1:0]     in_origin_z,
  input  logic [fbc_pkg::EXTENT_W-1:0]           in_extent_x,
  input  logic [fbc_pkg::EXTENT_W-1:0]           in_extent_y,
  input  logic [fbc_pkg::EXTENT_W-1:0]           in_extent_z,
  input  logic                                   out_valid,
  input  logic                                   out_visible,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  fbc_pkg::reg_idx_t                      cfg_index,
  input  logic [fbc_pkg::PLANE_W-1:0]            cfg_data,
  output int                                     fail_count,
  output int                                     pending
);
  import fbc_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [PLANE_W-1:0]  plane_mirror [NUM_PLANES];
  logic [CORNER_W-1:0] corner_low_mirror;
  logic [CORNER_W-1:0] corner_high_mirror;
  logic                visible_expected_q [$];
  logic                want;
  int                  results_seen;

  function automatic logic predict_visible(
    input logic                        is_point,
    input logic signed [COORD_W-1:0]   ox,
    input logic signed [COORD_W-1:0]   oy,
    input logic signed [COORD_W-1:0]   oz,
    input logic [EXTENT_W-1:0]         ex,
    input logic [EXTENT_W-1:0]         ey,
    input logic [EXTENT_W-1:0]         ez
  );
    longint lo [NUM_AXES];
    longint hi [NUM_AXES];
    longint coef;
    longint dot;
    logic   vis;
    lo[0] = ox;
    lo[1] = oy;
    lo[2] = oz;
    hi[0] = lo[0] + longint'(ex);
    hi[1] = lo[1] + longint'(ey);
    hi[2] = lo[2] + longint'(ez);
    vis = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      // The offset term is scaled by 16 to line up with the coordinate fraction bits.
      dot = longint'($signed(plane_mirror[p][3*COEF_W +: COEF_W])) * 16;
      for (int k = 0; k < NUM_AXES; k++) begin
        coef = longint'($signed(plane_mirror[p][k*COEF_W +: COEF_W]));
        // A box is judged by the corner lying farthest in front of the plane.
        if (is_point || coef < 0) begin
          dot += coef * lo[k];
        end else begin
          dot += coef * hi[k];
        end
      end
      if (dot < 0) vis = 1'b0;
    end
    if (!is_point) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if (longint'($signed(corner_low_mirror[k*COORD_W +: COORD_W])) > hi[k]) vis = 1'b0;
        if (longint'($signed(corner_high_mirror[k*COORD_W +: COORD_W])) < lo[k]) vis = 1'b0;
      end
    end
    return vis;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) plane_mirror[p] <= '0;
      corner_low_mirror  <= '0;
      corner_high_mirror <= '0;
      visible_expected_q.delete();
      fail_count   <= 0;
      pending      <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (visible_expected_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("result %0d arrived with no query outstanding (visible %0b)",
                     results_seen, out_visible);
          fail_count <= fail_count + 1;
        end else begin
          want = visible_expected_q.pop_front();
          if (out_visible !== want) begin
            if (fail_count < MAX_REPORTS)
              $display("visibility mismatch on result %0d: expected %0b, got %0b",
                       results_seen, want, out_visible);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CORNER_LOW: begin
            corner_low_mirror <= cfg_data[CORNER_W-1:0];
          end
          REG_CORNER_HIGH: begin
            corner_high_mirror <= cfg_data[CORNER_W-1:0];
          end
          default: begin
            plane_mirror[cfg_index] <= cfg_data;
          end
        endcase
      end
      if (start && !busy)
        visible_expected_q.push_back(predict_visible(in_command, in_origin_x, in_origin_y,
                                                     in_origin_z, in_extent_x, in_extent_y,
                                                     in_extent_z));
      pending <= visible_expected_q.size();
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top for the frustum box cull unit: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps
module tb_top;
  import fbc_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int COORD_MIN     = -524288;
  localparam int COORD_MAX     = 524287;
  localparam int EXTENT_MAX    = 65535;
  localparam int FULL_SPAN     = 262144;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_command;
  logic signed [COORD_W-1:0]   in_origin_x;
  logic signed [COORD_W-1:0]   in_origin_y;
  logic signed [COORD_W-1:0]   in_origin_z;
  logic [EXTENT_W-1:0]         in_extent_x;
  logic [EXTENT_W-1:0]         in_extent_y;
  logic [EXTENT_W-1:0]         in_extent_z;
  logic                        out_valid;
  logic                        out_visible;
  logic                        cfg_valid;
  logic                        cfg_ready;
  reg_idx_t                    cfg_index;
  logic [PLANE_W-1:0]          cfg_data;
  int                          fail_count;
  int                          pending;
  int                          cycle_count = 0;

  // Configuration to be loaded next, and the region the random queries aim at.
  logic [PLANE_W-1:0]          plane_set [NUM_PLANES];
  logic [CORNER_W-1:0]         corner_low_set;
  logic [CORNER_W-1:0]         corner_high_set;
  int                          aim_mid [NUM_AXES];
  int                          aim_span [NUM_AXES];

  frustum_box_cull_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_command  (in_command),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .in_origin_z (in_origin_z),
    .in_extent_x (in_extent_x),
    .in_extent_y (in_extent_y),
    .in_extent_z (in_extent_z),
    .out_valid   (out_valid),
    .out_visible (out_visible),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  cull_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_command  (in_command),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .in_origin_z (in_origin_z),
    .in_extent_x (in_extent_x),
    .in_extent_y (in_extent_y),
    .in_extent_z (in_extent_z),
    .out_valid   (out_valid),
    .out_visible (out_visible),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [PLANE_W-1:0] pack_plane(input int a, input int b,
                                                     input int c, input int d);
    return {COEF_W'(d), COEF_W'(c), COEF_W'(b), COEF_W'(a)};
  endfunction

  function automatic logic [CORNER_W-1:0] pack_corner(input int x, input int y,
                                                       input int z);
    return {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
  endfunction

  // Plane facing along one axis with the given gain, now and then tilted slightly.
  function automatic logic [PLANE_W-1:0] axis_plane(input int axis, input int gain,
                                                     input int offset);
    int coef [NUM_AXES];
    for (int k = 0; k < NUM_AXES; k++) begin
      coef[k] = 0;
      if ($urandom_range(0, 7) == 0) coef[k] = int'($urandom_range(0, 2)) - 1;
    end
    coef[axis] = gain;
    return pack_plane(coef[0], coef[1], coef[2], offset);
  endfunction

  task automatic offer_query(input logic cmd,
                             input int ox, input int oy, input int oz,
                             input int ex, input int ey, input int ez);
    @(negedge clk);
    start       <= 1'b1;
    in_command  <= cmd;
    in_origin_x <= COORD_W'(ox);
    in_origin_y <= COORD_W'(oy);
    in_origin_z <= COORD_W'(oz);
    in_extent_x <= EXTENT_W'(ex);
    in_extent_y <= EXTENT_W'(ey);
    in_extent_z <= EXTENT_W'(ez);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [PLANE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes the staged configuration; the spare upper bits of the corner words carry noise.
  task automatic apply_config();
    logic [PLANE_W-CORNER_W-1:0] junk;
    for (int p = 0; p < NUM_PLANES; p++) write_register(reg_idx_t'(p), plane_set[p]);
    junk = (PLANE_W-CORNER_W)'($urandom);
    write_register(REG_CORNER_LOW, {junk, corner_low_set});
    junk = (PLANE_W-CORNER_W)'($urandom);
    write_register(REG_CORNER_HIGH, {junk, corner_high_set});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_config(input logic [PLANE_W-1:0] plane_value,
                             input logic [CORNER_W-1:0] low_value,
                             input logic [CORNER_W-1:0] high_value);
    for (int p = 0; p < NUM_PLANES; p++) plane_set[p] = plane_value;
    corner_low_set  = low_value;
    corner_high_set = high_value;
    apply_config();
  endtask

  task automatic set_aim(input int mid, input int span);
    for (int k = 0; k < NUM_AXES; k++) begin
      aim_mid[k]  = mid;
      aim_span[k] = span;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Axis-aligned frustum with random bounds; planes and corner bounds roughly agree.
  task automatic load_box_frustum();
    int mid;
    int half;
    int lo_b;
    int hi_b;
    int gain;
    logic [PLANE_W-1:0] lower;
    logic [PLANE_W-1:0] upper;
    for (int k = 0; k < NUM_AXES; k++) begin
      mid  = int'($urandom_range(0, 200000)) - 100000;
      half = int'($urandom_range(16, 60000));
      lo_b = mid - half;
      hi_b = mid + half;
      gain = int'($urandom_range(1, 3));
      aim_mid[k]  = mid;
      aim_span[k] = half;
      lower = axis_plane(k, gain, -(lo_b * gain) / 16);
      upper = axis_plane(k, -gain, (hi_b * gain) / 16);
      case (k)
        0: begin
          plane_set[REG_PLANE_LEFT]  = lower;
          plane_set[REG_PLANE_RIGHT] = upper;
        end
        1: begin
          plane_set[REG_PLANE_BOTTOM] = lower;
          plane_set[REG_PLANE_TOP]    = upper;
        end
        default: begin
          plane_set[REG_PLANE_NEAR] = lower;
          plane_set[REG_PLANE_FAR]  = upper;
        end
      endcase
      corner_low_set[k*COORD_W +: COORD_W] =
        COORD_W'(lo_b + int'($urandom_range(0, 128)) - 64);
      corner_high_set[k*COORD_W +: COORD_W] =
        COORD_W'(hi_b + int'($urandom_range(0, 128)) - 64);
    end
    apply_config();
  endtask

  task automatic stream_queries(input int count);
    int burst_left;
    int gap;
    int r;
    int org [NUM_AXES];
    int ext [NUM_AXES];
    burst_left = int'($urandom_range(1, 24));
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          org[k] = int'($signed(COORD_W'($urandom)));
        end else begin
          r = aim_mid[k] + int'($urandom_range(0, 4 * aim_span[k])) - 2 * aim_span[k];
          if (r < COORD_MIN) r = COORD_MIN;
          if (r > COORD_MAX) r = COORD_MAX;
          org[k] = r;
        end
        case ($urandom_range(0, 3))
          0: begin
            ext[k] = 0;
          end
          1: begin
            ext[k] = int'($urandom_range(0, EXTENT_MAX));
          end
          default: begin
            ext[k] = int'($urandom_range(0, aim_span[k] > EXTENT_MAX ? EXTENT_MAX
                                                                      : aim_span[k]));
          end
        endcase
      end
      offer_query(1'($urandom_range(0, 1)), org[0], org[1], org[2], ext[0], ext[1],
                  ext[2]);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = int'($urandom_range(1, 24));
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
        if (gap > 0) begin
          @(negedge clk);
          start <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_command  = CMD_BOX;
    in_origin_x = '0;
    in_origin_y = '0;
    in_origin_z = '0;
    in_extent_x = '0;
    in_extent_y = '0;
    in_extent_z = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_PLANE_NEAR;
    cfg_data    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers at reset: planes pass everything, corner bounds sit at the origin.
    offer_query(CMD_POINT, 0, 0, 0, 0, 0, 0);
    offer_query(CMD_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0);
    offer_query(CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN, EXTENT_MAX, EXTENT_MAX,
                EXTENT_MAX);
    offer_query(CMD_BOX, 1, 0, 0, 0, 0, 0);
    offer_query(CMD_BOX, 0, 0, 0, 0, 0, 0);
    offer_query(CMD_BOX, -1, -1, -1, 0, 0, 0);
    offer_query(CMD_BOX, -1, -1, -1, 1, 1, 1);
    offer_query(CMD_BOX, COORD_MIN, COORD_MIN, COORD_MIN, EXTENT_MAX, EXTENT_MAX,
                EXTENT_MAX);
    offer_query(CMD_BOX, COORD_MAX, COORD_MAX, COORD_MAX, EXTENT_MAX, EXTENT_MAX,
                EXTENT_MAX);
    offer_query(CMD_BOX, -65535, -65535, -65535, EXTENT_MAX, EXTENT_MAX, EXTENT_MAX);
    drain_results();

    // Unit planes at +-1600 on every axis; corner bounds wider on x and z, tighter on y.
    plane_set[REG_PLANE_LEFT]   = pack_plane(1, 0, 0, 100);
    plane_set[REG_PLANE_RIGHT]  = pack_plane(-1, 0, 0, 100);
    plane_set[REG_PLANE_BOTTOM] = pack_plane(0, 1, 0, 100);
    plane_set[REG_PLANE_TOP]    = pack_plane(0, -1, 0, 100);
    plane_set[REG_PLANE_NEAR]   = pack_plane(0, 0, 1, 100);
    plane_set[REG_PLANE_FAR]    = pack_plane(0, 0, -1, 100);
    corner_low_set  = pack_corner(-2000, -1000, -2000);
    corner_high_set = pack_corner(2000, 1000, 2000);
    apply_config();
    // Points and boxes landing exactly on a plane or a corner bound, and one step past it.
    offer_query(CMD_POINT, -1600, 0, 0, 0, 0, 0);
    offer_query(CMD_POINT, -1601, 0, 0, 0, 0, 0);
    offer_query(CMD_POINT, 0, 0, 1600, 0, 0, 0);
    offer_query(CMD_POINT, 0, 0, 1601, 0, 0, 0);
    offer_query(CMD_BOX, -1700, 0, 0, 100, 0, 0);
    offer_query(CMD_BOX, -1700, 0, 0, 99, 0, 0);
    offer_query(CMD_BOX, 0, -1100, 0, 0, 100, 0);
    offer_query(CMD_BOX, 0, -1100, 0, 0, 99, 0);
    offer_query(CMD_BOX, 0, 1000, 0, 0, 0, 0);
    offer_query(CMD_BOX, 0, 1001, 0, 0, 0, 0);
    offer_query(CMD_BOX, -5000, -5000, -5000, 10000, 10000, 10000);
    set_aim(0, 2000);
    stream_queries(150);

    for (int f = 0; f < 4; f++) begin
      drain_results();
      load_box_frustum();
      stream_queries(150);
    end

    drain_results();
    for (int p = 0; p < NUM_PLANES; p++) plane_set[p] = {$urandom, $urandom};
    corner_low_set  = CORNER_W'({$urandom, $urandom});
    corner_high_set = CORNER_W'({$urandom, $urandom});
    apply_config();
    set_aim(0, FULL_SPAN);
    stream_queries(100);

    drain_results();
    fill_config({4{16'h7FFF}}, {3{20'h80000}}, {3{20'h7FFFF}});
    stream_queries(100);

    // Low bounds above high bounds are used exactly as written.
    drain_results();
    fill_config({4{16'h8000}}, {3{20'h7FFFF}}, {3{20'h80000}});
    stream_queries(100);

    drain_results();
    fill_config('1, '1, '1);
    stream_queries(100);

    drain_results();
    fill_config('0, '0, '0);
    stream_queries(50);

    drain_results();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
